// File: sv/hsfd_pkg.sv
package hsfd_pkg;

  // Buffer sizing and per-word result limit
  localparam int unsigned MAX_FRAME_BYTES_DEF = 32;
  localparam int unsigned MAX_RESULTS         = 16;

  // Header bytes
  localparam logic [7:0] SYNC_A = 8'hEF;
  localparam logic [7:0] SYNC_B = 8'hDD;

  // Message types
  localparam logic [7:0] MT_SETTINGS = 8'h08;
  localparam logic [7:0] MT_TIMER    = 8'h07;
  localparam logic [7:0] MT_EVENT    = 8'h0C;

  // Event identifiers
  localparam logic [7:0] EV_EXT     = 8'h0B;
  localparam logic [7:0] EV_WEIGHT  = 8'h05;
  localparam logic [7:0] EV_BATTERY = 8'h06;
  localparam logic [7:0] EV_TIMER   = 8'h07;
  localparam logic [7:0] EV_KEY     = 8'h08;

  typedef enum logic [1:0] {
    VERDICT_OK,
    VERDICT_BAD_LEN,
    VERDICT_BAD_SUM
  } verdict_t;

  typedef enum logic [2:0] {
    KIND_SETTINGS,
    KIND_TIMER,
    KIND_WEIGHT,
    KIND_BATTERY,
    KIND_KEY,
    KIND_UNKNOWN,
    KIND_REJECTED
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HUNT_RD,
    ST_HUNT_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT,
    ST_DONE
  } eng_state_t;

  // Received word with its header classification
  typedef struct packed {
    logic [7:0] data;
    logic       is_a;
    logic       is_b;
  } rx_word_t;

  // Engine status seen by the top level
  typedef struct packed {
    logic idle;
    logic pend_valid;
    logic fill_bad;
  } eng_status_t;

  // Inbound classification of an accepted frame
  function automatic kind_t classify(input logic [7:0] mtype, input logic [7:0] bl,
                                     input logic [7:0] p0, input logic [7:0] p3);
    kind_t k;
    k = KIND_UNKNOWN;
    if (mtype == MT_SETTINGS) begin
      k = KIND_SETTINGS;
    end else if (mtype == MT_TIMER) begin
      k = KIND_TIMER;
    end else if (mtype == MT_EVENT) begin
      if (bl == 8'd1) begin
        k = KIND_REJECTED;
      end else if (p0 == EV_EXT) begin
        if (bl < 8'd5) begin
          k = KIND_UNKNOWN;
        end else if (p3 == EV_WEIGHT) begin
          k = (bl >= 8'd11) ? KIND_WEIGHT : KIND_UNKNOWN;
        end else if (p3 == EV_TIMER) begin
          k = (bl >= 8'd8) ? KIND_TIMER : KIND_UNKNOWN;
        end else begin
          k = KIND_UNKNOWN;
        end
      end else if (p0 == EV_WEIGHT) begin
        k = KIND_WEIGHT;
      end else if (p0 == EV_BATTERY) begin
        k = KIND_BATTERY;
      end else if (p0 == EV_TIMER) begin
        k = KIND_TIMER;
      end else if (p0 == EV_KEY) begin
        k = KIND_KEY;
      end else begin
        k = KIND_UNKNOWN;
      end
    end
    return k;
  endfunction

endpackage

// File: sv/hsfd_front.sv
module hsfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_stall,
  input  logic [7:0]        rx_byte,
  output logic              q_valid,
  output hsfd_pkg::rx_word_t q_word,
  input  logic              q_pop
);
  import hsfd_pkg::*;

  rx_word_t   slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  rx_word_t   in_word;

  // Classify the incoming word against the header bytes
  always_comb begin
    in_word.data = rx_byte;
    in_word.is_a = (rx_byte == SYNC_A);
    in_word.is_b = (rx_byte == SYNC_B);
  end

  assign rx_stall = (cnt == 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_word   = slot[rptr];
  assign push     = rx_valid && !rx_stall;
  assign pop      = q_pop && q_valid;

  // Hold words in a two-entry queue
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= in_word;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

// File: sv/hsfd_engine.sv
module hsfd_engine #(
  parameter int unsigned MAX_FRAME_BYTES = hsfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  hsfd_pkg::rx_word_t    q_word,
  output logic                  q_pop,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [1:0]            verdict,
  output logic [7:0]            msg_type,
  output logic [5:0]            wire_length,
  output logic [2:0]            inbound_kind,
  output logic [7:0]            event_id,
  output logic                  last,
  output hsfd_pkg::eng_status_t status
);
  import hsfd_pkg::*;

  localparam int unsigned N  = MAX_FRAME_BYTES;
  localparam int unsigned AW = $clog2(N);
  localparam int unsigned FW = $clog2(N + 1);
  localparam int unsigned SW = FW + 1;
  localparam int unsigned CW = $clog2(MAX_RESULTS + 1);
  localparam logic [8:0]    MAX_BODY  = 9'(N - 5);
  localparam logic [FW-1:0] FILL_FULL = FW'(N);

  // Circular buffer storage
  logic [7:0]    mem [N];
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          wr_en;
  logic [7:0]    rd_data;

  eng_state_t state, state_next;
  logic [AW-1:0] head, head_next;
  logic [FW-1:0] fill, fill_next;
  logic [FW-1:0] idx, idx_next;
  logic          hfirst, hfirst_next;
  logic [7:0]    prev, prev_next;
  logic [7:0]    mtype, mtype_next;
  logic [7:0]    bl, bl_next;
  logic [7:0]    se, se_next;
  logic [7:0]    so, so_next;
  logic [7:0]    p0, p0_next;
  logic [7:0]    p3, p3_next;
  logic [7:0]    ck0, ck0_next;
  logic [CW-1:0] cnt, cnt_next;

  verdict_t      res_verdict, res_verdict_next;
  logic [5:0]    res_len, res_len_next;
  kind_t         res_kind, res_kind_next;
  logic [7:0]    res_ev, res_ev_next;
  logic [7:0]    res_type, res_type_next;
  logic          res_accept, res_accept_next;

  logic          pend_valid, pend_valid_next;
  verdict_t      pend_verdict, pend_verdict_next;
  logic [7:0]    pend_type, pend_type_next;
  logic [5:0]    pend_len, pend_len_next;
  kind_t         pend_kind, pend_kind_next;
  logic [7:0]    pend_ev, pend_ev_next;

  logic          out_valid, out_valid_next;
  verdict_t      out_verdict, out_verdict_next;
  logic [7:0]    out_type, out_type_next;
  logic [5:0]    out_len, out_len_next;
  kind_t         out_kind, out_kind_next;
  logic [7:0]    out_ev, out_ev_next;
  logic          out_last, out_last_next;

  logic          can_load;
  logic [8:0]    need;
  logic          sum_ok;
  logic          proceed;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [FW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(N)) begin
      s = s - SW'(N);
    end
    return s[AW-1:0];
  endfunction

  // Write and read the buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign can_load = !out_valid || !res_stall;
  assign need     = 9'(bl) + 9'd5;
  assign sum_ok   = (se == ck0) && (so == rd_data);

  // Next state and datapath
  always_comb begin
    state_next        = state;
    head_next         = head;
    fill_next         = fill;
    idx_next          = idx;
    hfirst_next       = hfirst;
    prev_next         = prev;
    mtype_next        = mtype;
    bl_next           = bl;
    se_next           = se;
    so_next           = so;
    p0_next           = p0;
    p3_next           = p3;
    ck0_next          = ck0;
    cnt_next          = cnt;
    res_verdict_next  = res_verdict;
    res_len_next      = res_len;
    res_kind_next     = res_kind;
    res_ev_next       = res_ev;
    res_type_next     = res_type;
    res_accept_next   = res_accept;
    pend_valid_next   = pend_valid;
    pend_verdict_next = pend_verdict;
    pend_type_next    = pend_type;
    pend_len_next     = pend_len;
    pend_kind_next    = pend_kind;
    pend_ev_next      = pend_ev;
    out_valid_next    = out_valid;
    out_verdict_next  = out_verdict;
    out_type_next     = out_type;
    out_len_next      = out_len;
    out_kind_next     = out_kind;
    out_ev_next       = out_ev;
    out_last_next     = out_last;
    q_pop             = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = wrap_add(head, fill);
    wr_data           = q_word.data;
    rd_addr           = wrap_add(head, idx);
    proceed           = 1'b0;

    // Drop the output word once taken
    if (out_valid && !res_stall) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (q_valid) begin
          q_pop = 1'b1;
          // Store the word according to the hunt progress
          priority if (fill == '0) begin
            wr_en   = q_word.is_a;
            wr_addr = head;
            fill_next = q_word.is_a ? FW'(1) : '0;
          end else if (fill == FW'(1)) begin
            wr_addr = wrap_add(head, FW'(1));
            if (q_word.is_b) begin
              wr_en     = 1'b1;
              fill_next = FW'(2);
            end else if (!q_word.is_a) begin
              fill_next = '0;
            end
          end else if (fill >= FILL_FULL) begin
            wr_en     = q_word.is_a;
            wr_addr   = head;
            fill_next = q_word.is_a ? FW'(1) : '0;
          end else begin
            wr_en     = 1'b1;
            fill_next = fill + FW'(1);
          end
          if (fill_next != '0) begin
            idx_next    = '0;
            hfirst_next = 1'b1;
            state_next  = ST_HUNT_RD;
          end
        end
      end

      ST_HUNT_RD: begin
        state_next = ST_HUNT_CHK;
      end

      ST_HUNT_CHK: begin
        if (!hfirst && prev == SYNC_A && rd_data == SYNC_B) begin
          // Header found: move the head onto it
          head_next = wrap_add(head, idx - FW'(1));
          fill_next = fill - idx + FW'(1);
          if (fill_next < FW'(4)) begin
            state_next = ST_DONE;
          end else begin
            idx_next   = FW'(2);
            state_next = ST_SCAN_RD;
          end
        end else if (SW'(idx) + SW'(1) >= SW'(fill)) begin
          // No header: keep a trailing first header byte
          if (rd_data == SYNC_A) begin
            head_next = wrap_add(head, idx);
            fill_next = FW'(1);
          end else begin
            fill_next = '0;
          end
          state_next = ST_DONE;
        end else begin
          prev_next   = rd_data;
          hfirst_next = 1'b0;
          idx_next    = idx + FW'(1);
          state_next  = ST_HUNT_RD;
        end
      end

      ST_SCAN_RD: begin
        state_next = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        res_type_next = mtype;
        if (9'(idx) == 9'd2) begin
          mtype_next = rd_data;
          idx_next   = idx + FW'(1);
          state_next = ST_SCAN_RD;
        end else if (9'(idx) == 9'd3) begin
          bl_next = rd_data;
          if (rd_data == 8'd0 || 9'(rd_data) > MAX_BODY) begin
            res_verdict_next = VERDICT_BAD_LEN;
            res_len_next     = 6'd4;
            res_kind_next    = KIND_REJECTED;
            res_ev_next      = 8'd0;
            res_accept_next  = 1'b0;
            state_next       = ST_EMIT;
          end else if (9'(fill) < 9'(rd_data) + 9'd5) begin
            state_next = ST_DONE;
          end else begin
            se_next    = rd_data;
            so_next    = 8'd0;
            idx_next   = idx + FW'(1);
            state_next = ST_SCAN_RD;
          end
        end else begin
          // Accumulate the even and odd body sums
          if (9'(idx) < 9'(bl) + 9'd3) begin
            if (idx[0]) begin
              se_next = se + rd_data;
            end else begin
              so_next = so + rd_data;
            end
          end
          if (9'(idx) == 9'd4) begin
            p0_next = rd_data;
          end
          if (9'(idx) == 9'd7) begin
            p3_next = rd_data;
          end
          if (9'(idx) == need - 9'd2) begin
            ck0_next = rd_data;
          end
          if (9'(idx) == need - 9'd1) begin
            res_verdict_next = sum_ok ? VERDICT_OK : VERDICT_BAD_SUM;
            res_len_next     = need[5:0];
            res_kind_next    = sum_ok ? classify(mtype, bl, p0, p3) : KIND_REJECTED;
            res_ev_next      = (bl >= 8'd2) ? p0 : 8'd0;
            res_accept_next  = sum_ok;
            state_next       = ST_EMIT;
          end else begin
            idx_next   = idx + FW'(1);
            state_next = ST_SCAN_RD;
          end
        end
      end

      ST_EMIT: begin
        // Stage the result, or drop it once the per-word limit is reached; the pending one goes out as not last
        if (cnt >= CW'(MAX_RESULTS)) begin
          proceed = 1'b1;
        end else if (!pend_valid || can_load) begin
          proceed = 1'b1;
          if (pend_valid) begin
            out_valid_next   = 1'b1;
            out_verdict_next = pend_verdict;
            out_type_next    = pend_type;
            out_len_next     = pend_len;
            out_kind_next    = pend_kind;
            out_ev_next      = pend_ev;
            out_last_next    = 1'b0;
          end
          pend_valid_next   = 1'b1;
          pend_verdict_next = res_verdict;
          pend_type_next    = res_type;
          pend_len_next     = res_len;
          pend_kind_next    = res_kind;
          pend_ev_next      = res_ev;
          cnt_next          = cnt + CW'(1);
        end
        if (proceed) begin
          hfirst_next = 1'b1;
          if (res_accept) begin
            head_next = wrap_add(head, FW'(need));
            fill_next = fill - FW'(need);
            idx_next  = '0;
            state_next = (fill_next != '0) ? ST_HUNT_RD : ST_DONE;
          end else begin
            idx_next   = FW'(1);
            state_next = ST_HUNT_RD;
          end
        end
      end

      ST_DONE: begin
        // Release the final result of this word marked last
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (can_load) begin
          out_valid_next   = 1'b1;
          out_verdict_next = pend_verdict;
          out_type_next    = pend_type;
          out_len_next     = pend_len;
          out_kind_next    = pend_kind;
          out_ev_next      = pend_ev;
          out_last_next    = 1'b1;
          pend_valid_next  = 1'b0;
          state_next       = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      fill       <= '0;
      cnt        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      fill       <= fill_next;
      cnt        <= cnt_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx          <= idx_next;
    hfirst       <= hfirst_next;
    prev         <= prev_next;
    mtype        <= mtype_next;
    bl           <= bl_next;
    se           <= se_next;
    so           <= so_next;
    p0           <= p0_next;
    p3           <= p3_next;
    ck0          <= ck0_next;
    res_verdict  <= res_verdict_next;
    res_len      <= res_len_next;
    res_kind     <= res_kind_next;
    res_ev       <= res_ev_next;
    res_type     <= res_type_next;
    res_accept   <= res_accept_next;
    pend_verdict <= pend_verdict_next;
    pend_type    <= pend_type_next;
    pend_len     <= pend_len_next;
    pend_kind    <= pend_kind_next;
    pend_ev      <= pend_ev_next;
    out_verdict  <= out_verdict_next;
    out_type     <= out_type_next;
    out_len      <= out_len_next;
    out_kind     <= out_kind_next;
    out_ev       <= out_ev_next;
    out_last     <= out_last_next;
  end

  assign res_valid    = out_valid;
  assign verdict      = out_verdict;
  assign msg_type     = out_type;
  assign wire_length  = out_len;
  assign inbound_kind = out_kind;
  assign event_id     = out_ev;
  assign last         = out_last;

  always_comb begin
    status.idle       = (state == ST_IDLE);
    status.pend_valid = pend_valid;
    status.fill_bad   = (fill > FILL_FULL);
  end

endmodule

// File: sv/header_sync_frame_deframer.sv
// Flow: a word leaves the input queue, then the buffer engine reads the buffered bytes in a
// header hunt, checks each frame byte, stages each result and releases the last one, and
// rejects can cascade through the buffer.
// Throughput: one word at a time, set by the single read port of the frame buffer.
// Reset: synchronous, clears the queue, buffer fill and result valid flags; contents stay.
module header_sync_frame_deframer #(
  parameter int unsigned MAX_FRAME_BYTES = hsfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] verdict,
  output logic [7:0] msg_type,
  output logic [5:0] wire_length,
  output logic [2:0] inbound_kind,
  output logic [7:0] event_id,
  output logic       last
);
  import hsfd_pkg::*;

  logic        q_valid;
  rx_word_t    q_word;
  logic        q_pop;
  eng_status_t status;

  // Accept and classify words
  hsfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  // Buffer, hunt, check and report frames
  hsfd_engine #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_word       (q_word),
    .q_pop        (q_pop),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .verdict      (verdict),
    .msg_type     (msg_type),
    .wire_length  (wire_length),
    .inbound_kind (inbound_kind),
    .event_id     (event_id),
    .last         (last),
    .status       (status)
  );

`ifndef SYNTH
  a_fill_in_range: assert property (@(posedge clk) disable iff (rst) !status.fill_bad)
    else $error("buffer fill beyond capacity");
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    status.idle |-> !status.pend_valid)
    else $error("result left pending while idle");
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");
`endif

endmodule

// File: test/header_sync_frame_deframer_tb.sv
`timescale 1ns / 1ps

module header_sync_frame_deframer_tb;
  import hsfd_pkg::*;

  localparam int unsigned BUF_BYTES = 32;
  localparam int unsigned WATCHDOG_CYCLES = 20000;

  typedef struct packed {
    logic [1:0] verdict;
    logic [7:0] msg_type;
    logic [5:0] wire_length;
    logic [2:0] inbound_kind;
    logic [7:0] event_id;
    logic       last;
  } frame_report_t;

  // Directed stimulus row: one received word, optional report typed in by hand
  typedef struct packed {
    logic [7:0]    data;
    logic          has_report;
    frame_report_t report;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'd0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [1:0] verdict;
  logic [7:0] msg_type;
  logic [5:0] wire_length;
  logic [2:0] inbound_kind;
  logic [7:0] event_id;
  logic       last;

  logic [7:0]    rx_buf [BUF_BYTES];
  int unsigned   rx_fill;
  frame_report_t pending_reports [$];
  logic [7:0]    word_queue [$];
  int unsigned   fail_count = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   stall_left = 0;

  header_sync_frame_deframer uut (
    .clk(clk), .rst(rst), .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
    .res_valid(res_valid), .res_stall(res_stall), .verdict(verdict), .msg_type(msg_type),
    .wire_length(wire_length), .inbound_kind(inbound_kind), .event_id(event_id),
    .last(last)
  );

  always #2 clk = ~clk;

  // ---------------- deframer predictor ----------------
  function automatic void buf_drop(int unsigned n);
    if (n >= rx_fill) begin
      rx_fill = 0;
      return;
    end
    for (int unsigned i = 0; i < rx_fill - n; i++) rx_buf[i] = rx_buf[i + n];
    rx_fill -= n;
  endfunction

  function automatic void buf_resync(int unsigned start);
    for (int unsigned i = start; i + 1 < rx_fill; i++) begin
      if (rx_buf[i] == SYNC_A && rx_buf[i + 1] == SYNC_B) begin
        if (i != 0) buf_drop(i);
        return;
      end
    end
    if (rx_fill > 0 && rx_buf[rx_fill - 1] == SYNC_A) begin
      rx_buf[0] = SYNC_A;
      rx_fill = 1;
    end else begin
      rx_fill = 0;
    end
  endfunction

  function automatic void buf_push(logic [7:0] b);
    if (rx_fill == 0) begin
      if (b == SYNC_A) rx_buf[rx_fill++] = b;
    end else if (rx_fill == 1) begin
      if (b == SYNC_B) rx_buf[rx_fill++] = b;
      else if (b != SYNC_A) rx_fill = 0;
    end else if (rx_fill >= BUF_BYTES) begin
      rx_fill = 0;
      if (b == SYNC_A) rx_buf[rx_fill++] = b;
    end else begin
      rx_buf[rx_fill++] = b;
    end
  endfunction

  function automatic kind_t frame_kind(int unsigned body_len);
    int unsigned plen;
    plen = body_len - 1;
    case (rx_buf[2])
      MT_SETTINGS: return KIND_SETTINGS;
      MT_TIMER:    return KIND_TIMER;
      MT_EVENT:    ;
      default:     return KIND_UNKNOWN;
    endcase
    if (plen < 1) return KIND_REJECTED;
    if (rx_buf[4] == EV_EXT) begin
      if (plen < 4) return KIND_UNKNOWN;
      if (rx_buf[7] == EV_WEIGHT) return plen >= 10 ? KIND_WEIGHT : KIND_UNKNOWN;
      if (rx_buf[7] == EV_TIMER) return plen >= 7 ? KIND_TIMER : KIND_UNKNOWN;
      return KIND_UNKNOWN;
    end
    case (rx_buf[4])
      EV_WEIGHT:  return KIND_WEIGHT;
      EV_BATTERY: return KIND_BATTERY;
      EV_TIMER:   return KIND_TIMER;
      EV_KEY:     return KIND_KEY;
      default:    return KIND_UNKNOWN;
    endcase
  endfunction

  // Advance the deframer by one word and return the reports it raises
  function automatic void deframe_word(logic [7:0] b, ref frame_report_t reps [$]);
    int unsigned body_len, need;
    logic [7:0]  se, so;
    frame_report_t r;
    reps = {};
    buf_push(b);
    forever begin
      if (rx_fill > 0) buf_resync(0);
      if (rx_fill < 4) break;
      body_len = rx_buf[3];
      r = '0;
      r.msg_type = rx_buf[2];
      if (body_len == 0 || body_len > BUF_BYTES - 5) begin
        r.verdict = VERDICT_BAD_LEN;
        r.wire_length = 6'd4;
        r.inbound_kind = KIND_REJECTED;
        if (reps.size() < MAX_RESULTS) reps.push_back(r);
        buf_resync(1);
        continue;
      end
      need = body_len + 5;
      if (rx_fill < need) break;
      se = 8'd0;
      so = 8'd0;
      for (int unsigned i = 0; i < body_len; i++) begin
        if (i[0] == 1'b0) se += rx_buf[3 + i];
        else so += rx_buf[3 + i];
      end
      r.wire_length = need[5:0];
      r.event_id = body_len >= 2 ? rx_buf[4] : 8'd0;
      if (se == rx_buf[need - 2] && so == rx_buf[need - 1]) begin
        r.verdict = VERDICT_OK;
        r.inbound_kind = frame_kind(body_len);
        if (reps.size() < MAX_RESULTS) reps.push_back(r);
        buf_drop(need);
      end else begin
        r.verdict = VERDICT_BAD_SUM;
        r.inbound_kind = KIND_REJECTED;
        if (reps.size() < MAX_RESULTS) reps.push_back(r);
        buf_resync(1);
      end
    end
    if (reps.size() > 0) reps[reps.size() - 1].last = 1'b1;
  endfunction

  // Queue a frame with random or chosen content, optionally with a corrupted checksum
  task automatic queue_frame(logic [7:0] mtype, int unsigned body_len, bit corrupt,
                             int ev = -1, int ev3 = -1);
    logic [7:0] body [$];
    logic [7:0] se, so;
    se = 8'd0;
    so = 8'd0;
    body.push_back(8'(body_len));
    for (int unsigned i = 1; i < body_len; i++) body.push_back(8'($urandom_range(0, 255)));
    if (ev >= 0 && body_len >= 2) body[1] = 8'(ev);
    if (ev3 >= 0 && body_len >= 5) body[4] = 8'(ev3);
    foreach (body[i]) begin
      if (i % 2 == 0) se += body[i];
      else so += body[i];
    end
    if (corrupt) so ^= 8'(1 << $urandom_range(0, 7));
    word_queue.push_back(SYNC_A);
    word_queue.push_back(SYNC_B);
    word_queue.push_back(mtype);
    foreach (body[i]) word_queue.push_back(body[i]);
    word_queue.push_back(se);
    word_queue.push_back(so);
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    frame_report_t got, want;
    if (!rst && res_valid && !res_stall) begin
      got = {verdict, msg_type, wire_length, inbound_kind, event_id, last};
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report %p", $time, got);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          $display("%0t: report mismatch expected %p actual %p", $time, want, got);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on accepted traffic
  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver stall: short gaps mostly, some long ones, quiet stretches
  always @(negedge clk) begin
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (rst) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      res_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ((($time / 4000) % 3) == 0) begin
      res_stall <= 1'b0;
    end else if (pick < 25) begin
      res_stall <= 1'b1;
    end else if (pick < 27) begin
      res_stall  <= 1'b1;
      stall_left <= $urandom_range(10, 40);
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Sender: present one word, hold until accepted, then random gap
  task automatic send_word(logic [7:0] b, ref frame_report_t reps [$]);
    int unsigned gap;
    rx_byte <= b;
    rx_valid <= 1'b1;
    do @(posedge clk); while (rx_stall);
    deframe_word(b, reps);
    foreach (reps[i]) pending_reports.push_back(reps[i]);
    @(negedge clk);
    gap = $urandom_range(0, 9) < 6 ? 0 :
          ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 60));
    if (gap != 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  stim_row_t stim_table [] = '{
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{SYNC_A, 1'b0, '0},
    '{SYNC_A, 1'b0, '0},
    '{SYNC_B, 1'b0, '0},
    '{MT_EVENT, 1'b0, '0},
    // zero body length: length reject
    '{8'h00, 1'b1, '{VERDICT_BAD_LEN, MT_EVENT, 6'd4, KIND_REJECTED, 8'd0, 1'b1}},
    '{SYNC_A, 1'b0, '0},
    '{SYNC_B, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    // body length above the buffer limit
    '{8'd28, 1'b1, '{VERDICT_BAD_LEN, 8'hFF, 6'd4, KIND_REJECTED, 8'd0, 1'b1}},
    // event frame without payload: length 1, sums 1 and 0
    '{SYNC_A, 1'b0, '0},
    '{SYNC_B, 1'b0, '0},
    '{MT_EVENT, 1'b0, '0},
    '{8'd1, 1'b0, '0},
    '{8'd1, 1'b0, '0},
    '{8'd0, 1'b1, '{VERDICT_OK, MT_EVENT, 6'd6, KIND_REJECTED, 8'd0, 1'b1}},
    // same frame with a bad checksum
    '{SYNC_A, 1'b0, '0},
    '{SYNC_B, 1'b0, '0},
    '{MT_EVENT, 1'b0, '0},
    '{8'd1, 1'b0, '0},
    '{8'd1, 1'b0, '0},
    '{8'd1, 1'b1, '{VERDICT_BAD_SUM, MT_EVENT, 6'd6, KIND_REJECTED, 8'd0, 1'b1}}
  };

  initial begin
    frame_report_t reps [$];
    int unsigned   pick, blen;
    rx_fill = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table; hand-typed reports cross-check the predictor
    foreach (stim_table[i]) begin
      send_word(stim_table[i].data, reps);
      if (stim_table[i].has_report &&
          (reps.size() != 1 || reps[0] !== stim_table[i].report)) begin
        $display("%0t: row %0d predictor expected %p actual %p", $time, i,
                 stim_table[i].report, reps.size() ? reps[0] : '0);
        fail_count++;
      end
    end

    // Fill the buffer to the limit: longest frame, extended event frames, then a longest frame header and junk
    queue_frame(MT_SETTINGS, 27, 1'b0);
    queue_frame(MT_EVENT, 12, 1'b0, EV_EXT, EV_WEIGHT);
    queue_frame(MT_EVENT, 8, 1'b0, EV_EXT, EV_TIMER);
    word_queue.push_back(SYNC_A);
    word_queue.push_back(SYNC_B);
    word_queue.push_back(MT_EVENT);
    word_queue.push_back(8'd27);
    repeat (30) word_queue.push_back(8'($urandom_range(0, 255)));
    word_queue.push_back(SYNC_A);

    // Random part: mostly frames, some noise and broken frames
    while (word_queue.size() < 480) begin
      pick = $urandom_range(0, 99);
      blen = $urandom_range(0, 9) == 0 ? $urandom_range(1, 27) : $urandom_range(1, 12);
      if (pick < 55) begin
        case ($urandom_range(0, 3))
          0: queue_frame(MT_SETTINGS, blen, 1'b0);
          1: queue_frame(MT_TIMER, blen, 1'b0);
          2: queue_frame(MT_EVENT, blen, 1'b0, $urandom_range(5, 11), $urandom_range(4, 8));
          default: queue_frame(8'($urandom_range(0, 255)), blen, 1'b0);
        endcase
      end else if (pick < 70) begin
        queue_frame(MT_EVENT, blen, 1'b1, $urandom_range(5, 11));
      end else if (pick < 80) begin
        word_queue.push_back(SYNC_A);
        word_queue.push_back(SYNC_B);
        word_queue.push_back(8'($urandom_range(0, 255)));
        word_queue.push_back($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(28, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0: word_queue.push_back(SYNC_A);
            1: word_queue.push_back(SYNC_B);
            default: word_queue.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end
    end
    while (word_queue.size() > 0) send_word(word_queue.pop_front(), reps);
    rx_valid <= 1'b0;

    while (pending_reports.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
